/* hdl/acd_pkg.sv */
package acd_pkg;

    // Fixed field widths
    localparam int GAIN_BITS      = 15;
    localparam int COEF_BITS      = 16;
    localparam int AP_LEN_BITS    = 12;
    localparam int COMB_LEN_BITS  = 13;
    localparam int REG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    // Allpass gain 0.55 in unsigned Q0.16
    localparam logic [COEF_BITS-1:0] DIFF_K = 16'd36045;

    // Register indexes
    localparam logic [REG_INDEX_BITS-1:0] REG_FIRST_LEN  = 2'd0;
    localparam logic [REG_INDEX_BITS-1:0] REG_SECOND_LEN = 2'd1;
    localparam logic [REG_INDEX_BITS-1:0] REG_COMB_LEN   = 2'd2;
    localparam logic [REG_INDEX_BITS-1:0] REG_DAMPING    = 2'd3;

    // Register reset values
    localparam logic [AP_LEN_BITS-1:0]   FIRST_LEN_RST  = 12'd629;
    localparam logic [AP_LEN_BITS-1:0]   SECOND_LEN_RST = 12'd946;
    localparam logic [COMB_LEN_BITS-1:0] COMB_LEN_RST   = 13'd1406;
    localparam logic [COEF_BITS-1:0]     DAMPING_RST    = 16'd15000;

    // Datapath step codes
    typedef logic [3:0] step_t;
    localparam step_t STEP_NONE  = 4'd0;
    localparam step_t STEP_1     = 4'd1;
    localparam step_t STEP_2     = 4'd2;
    localparam step_t STEP_3     = 4'd3;
    localparam step_t STEP_4     = 4'd4;
    localparam step_t STEP_5     = 4'd5;
    localparam step_t STEP_6     = 4'd6;
    localparam step_t STEP_7     = 4'd7;
    localparam step_t STEP_8     = 4'd8;
    localparam step_t STEP_FLUSH = 4'd9;

    // Controller to datapath commands
    typedef struct packed {
        logic  capture;
        step_t step;
        logic  out_load;
    } cmd_t;

    // Configuration register set
    typedef struct packed {
        logic [AP_LEN_BITS-1:0]   first_len;
        logic [AP_LEN_BITS-1:0]   second_len;
        logic [COMB_LEN_BITS-1:0] comb_len;
        logic [COEF_BITS-1:0]     damping;
    } cfg_t;

endpackage

/* hdl/acd_sample_if.sv */
interface acd_sample_if #(
    parameter int SAMPLE_BITS = 24
);
    import acd_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [GAIN_BITS-1:0]          loop_gain;
    logic                          flush;

    modport source (output valid, sample_in, loop_gain, flush, input ready);
    modport sink   (input valid, sample_in, loop_gain, flush, output ready);
endinterface

/* hdl/acd_result_if.sv */
interface acd_result_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, sample_out, input ready);
    modport sink   (input valid, sample_out, output ready);
endinterface

/* hdl/acd_cfg.sv */
module acd_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                we,
    input  logic [acd_pkg::REG_INDEX_BITS-1:0]  index,
    input  logic [acd_pkg::CFG_DATA_BITS-1:0]   data,
    output acd_pkg::cfg_t                       cfg
);
    import acd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (we)
        begin
            unique case (index)
                REG_FIRST_LEN:  cfg_next.first_len  = data[AP_LEN_BITS-1:0];
                REG_SECOND_LEN: cfg_next.second_len = data[AP_LEN_BITS-1:0];
                REG_COMB_LEN:   cfg_next.comb_len   = data[COMB_LEN_BITS-1:0];
                REG_DAMPING:    cfg_next.damping    = data[COEF_BITS-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_len  <= FIRST_LEN_RST;
            cfg_reg.second_len <= SECOND_LEN_RST;
            cfg_reg.comb_len   <= COMB_LEN_RST;
            cfg_reg.damping    <= DAMPING_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/acd_datapath.sv */
module acd_datapath #(
    parameter int ALLPASS_DEPTH = 2048,
    parameter int COMB_DEPTH    = 4096,
    parameter int SAMPLE_BITS   = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  acd_pkg::cmd_t                  cmd,
    input  acd_pkg::cfg_t                  cfg,
    input  logic signed [SAMPLE_BITS-1:0]  sample_in,
    input  logic [acd_pkg::GAIN_BITS-1:0]  loop_gain,
    output logic signed [SAMPLE_BITS-1:0]  sample_out
);
    import acd_pkg::*;

    localparam int W  = SAMPLE_BITS;
    localparam int EW = W + 2;            // rounded product / adder operand
    localparam int SW = W + 3;            // raw sum before saturation
    localparam int PW = W + COEF_BITS + 2; // full product
    localparam int AW = $clog2(ALLPASS_DEPTH);
    localparam int CW = $clog2(COMB_DEPTH);
    localparam int AL = (AW + 1 > AP_LEN_BITS) ? AW + 1 : AP_LEN_BITS;
    localparam int CL = (CW + 1 > COMB_LEN_BITS) ? CW + 1 : COMB_LEN_BITS;
    localparam logic signed [PW-1:0] ROUND_HALF = PW'(32768);

    // Saturating add or subtract to the sample width
    function automatic logic signed [W-1:0] sat_add(
        input logic signed [EW-1:0] a,
        input logic signed [EW-1:0] b,
        input logic                 sub
    );
        logic signed [SW-1:0] s;
        s = sub ? (SW'(a) - SW'(b)) : (SW'(a) + SW'(b));
        if (s[SW-1:W-1] == {(SW-W+1){s[SW-1]}})
            return s[W-1:0];
        else
            return {s[SW-1], {(W-1){~s[SW-1]}}};
    endfunction

    // Allpass position advance with length clamped to 1..depth
    function automatic logic [AW-1:0] adv_ap(
        input logic [AW-1:0]          pos,
        input logic [AP_LEN_BITS-1:0] len
    );
        logic [AL-1:0] eff;
        logic [AL-1:0] n;
        if (len == '0)
            eff = AL'(1);
        else if (AL'(len) > AL'(ALLPASS_DEPTH))
            eff = AL'(ALLPASS_DEPTH);
        else
            eff = AL'(len);
        n = AL'(pos) + AL'(1);
        return (n >= eff) ? '0 : n[AW-1:0];
    endfunction

    // Comb position advance with length clamped to 1..depth
    function automatic logic [CW-1:0] adv_cb(
        input logic [CW-1:0]            pos,
        input logic [COMB_LEN_BITS-1:0] len
    );
        logic [CL-1:0] eff;
        logic [CL-1:0] n;
        if (len == '0)
            eff = CL'(1);
        else if (CL'(len) > CL'(COMB_DEPTH))
            eff = CL'(COMB_DEPTH);
        else
            eff = CL'(len);
        n = CL'(pos) + CL'(1);
        return (n >= eff) ? '0 : n[CW-1:0];
    endfunction

    // Delay line stores
    logic signed [W-1:0] first_line  [ALLPASS_DEPTH];
    logic signed [W-1:0] second_line [ALLPASS_DEPTH];
    logic signed [W-1:0] comb_line   [COMB_DEPTH];

    // Control state (reset)
    logic [AW-1:0]       pos1_reg, pos1_next;
    logic [AW-1:0]       pos2_reg, pos2_next;
    logic [CW-1:0]       posc_reg, posc_next;
    logic [AW:0]         fill1_reg, fill1_next;
    logic [AW:0]         fill2_reg, fill2_next;
    logic [CW:0]         fillc_reg, fillc_next;
    logic signed [W-1:0] damper_reg, damper_next;

    // Payload registers
    logic signed [W-1:0]         x_reg;
    logic [GAIN_BITS-1:0]        gain_reg;
    logic signed [W-1:0]         q1_reg, q2_reg, qc_reg;
    logic                        hit1_reg, hit2_reg, hitc_reg;
    logic signed [EW-1:0]        pr_reg, pr_next;
    logic signed [EW-1:0]        gd_reg;
    logic signed [W:0]           diff_reg;
    logic signed [W-1:0]         v_reg, y_reg, res_reg, out_reg;

    // Line words, zero where not yet written since clear
    logic signed [W-1:0] d1, d2, c;
    assign d1 = hit1_reg ? q1_reg : '0;
    assign d2 = hit2_reg ? q2_reg : '0;
    assign c  = hitc_reg ? qc_reg : '0;

    // Shared multiplier with half-up rounding
    logic signed [W:0]           mul_a;
    logic [COEF_BITS-1:0]        mul_g;
    logic signed [PW-1:0]        prod_full;
    logic signed [PW-1:0]        prod_rnd;

    always_comb
    begin
        unique case (cmd.step)
            STEP_1:
            begin
                mul_a = (W+1)'(d1);
                mul_g = DIFF_K;
            end
            STEP_2:
            begin
                mul_a = diff_reg;
                mul_g = cfg.damping;
            end
            STEP_3:
            begin
                mul_a = (W+1)'(v_reg);
                mul_g = DIFF_K;
            end
            STEP_4:
            begin
                mul_a = (W+1)'(d2);
                mul_g = DIFF_K;
            end
            STEP_5:
            begin
                mul_a = (W+1)'(damper_reg);
                mul_g = {1'b0, gain_reg};
            end
            STEP_6:
            begin
                mul_a = (W+1)'(v_reg);
                mul_g = DIFF_K;
            end
            default:
            begin
                mul_a = '0;
                mul_g = '0;
            end
        endcase
    end

    assign prod_full = PW'(mul_a) * PW'($signed({1'b0, mul_g}));
    assign prod_rnd  = prod_full + ROUND_HALF;
    assign pr_next   = prod_rnd[PW-1:COEF_BITS];

    // Shared saturating adder
    logic signed [EW-1:0] add_a, add_b;
    logic                 add_sub;
    logic signed [W-1:0]  add_sum;
    logic signed [W-1:0]  res_sum;

    always_comb
    begin
        add_sub = 1'b0;
        unique case (cmd.step)
            STEP_2:
            begin
                add_a = EW'(x_reg);
                add_b = pr_reg;
            end
            STEP_3:
            begin
                add_a = EW'(damper_reg);
                add_b = pr_reg;
            end
            STEP_4:
            begin
                add_a   = EW'(d1);
                add_b   = pr_reg;
                add_sub = 1'b1;
            end
            STEP_5:
            begin
                add_a = EW'(y_reg);
                add_b = pr_reg;
            end
            STEP_7:
            begin
                add_a   = EW'(d2);
                add_b   = pr_reg;
                add_sub = 1'b1;
            end
            STEP_8:
            begin
                add_a = EW'(y_reg);
                add_b = gd_reg;
            end
            default:
            begin
                add_a = '0;
                add_b = '0;
            end
        endcase
    end

    assign add_sum = sat_add(add_a, add_b, add_sub);
    assign res_sum = sat_add(EW'(y_reg), EW'(c), 1'b0);

    // Payload pipeline
    always_ff @(posedge clk)
    begin
        pr_reg <= pr_next;
        if (cmd.capture)
        begin
            x_reg    <= sample_in;
            gain_reg <= loop_gain;
            hit1_reg <= ({1'b0, pos1_reg} < fill1_reg);
            hit2_reg <= ({1'b0, pos2_reg} < fill2_reg);
            hitc_reg <= ({1'b0, posc_reg} < fillc_reg);
        end
        unique case (cmd.step)
            STEP_1:     diff_reg <= (W+1)'(c) - (W+1)'(damper_reg);
            STEP_2:     v_reg    <= add_sum;
            STEP_4:     y_reg    <= add_sum;
            STEP_5:     v_reg    <= add_sum;
            STEP_6:     gd_reg   <= pr_reg;
            STEP_7:     y_reg    <= add_sum;
            STEP_8:     res_reg  <= res_sum;
            STEP_FLUSH: res_reg  <= '0;
            default:    ;
        endcase
        if (cmd.out_load)
            out_reg <= res_reg;
    end

    // Delay line memories
    always_ff @(posedge clk)
    begin
        if (cmd.step == STEP_3)
            first_line[pos1_reg] <= v_reg;
        if (cmd.capture)
            q1_reg <= first_line[pos1_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step == STEP_6)
            second_line[pos2_reg] <= v_reg;
        if (cmd.capture)
            q2_reg <= second_line[pos2_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step == STEP_8)
            comb_line[posc_reg] <= add_sum;
        if (cmd.capture)
            qc_reg <= comb_line[posc_reg];
    end

    // Positions, fill counts and damper level
    always_comb
    begin
        pos1_next   = pos1_reg;
        pos2_next   = pos2_reg;
        posc_next   = posc_reg;
        fill1_next  = fill1_reg;
        fill2_next  = fill2_reg;
        fillc_next  = fillc_reg;
        damper_next = damper_reg;
        unique case (cmd.step)
            STEP_3:
            begin
                damper_next = add_sum;
                if ({1'b0, pos1_reg} == fill1_reg)
                    fill1_next = fill1_reg + (AW+1)'(1);
            end
            STEP_6:
            begin
                if ({1'b0, pos2_reg} == fill2_reg)
                    fill2_next = fill2_reg + (AW+1)'(1);
            end
            STEP_8:
            begin
                if ({1'b0, posc_reg} == fillc_reg)
                    fillc_next = fillc_reg + (CW+1)'(1);
                pos1_next = adv_ap(pos1_reg, cfg.first_len);
                pos2_next = adv_ap(pos2_reg, cfg.second_len);
                posc_next = adv_cb(posc_reg, cfg.comb_len);
            end
            STEP_FLUSH:
            begin
                pos1_next   = '0;
                pos2_next   = '0;
                posc_next   = '0;
                fill1_next  = '0;
                fill2_next  = '0;
                fillc_next  = '0;
                damper_next = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos1_reg   <= '0;
            pos2_reg   <= '0;
            posc_reg   <= '0;
            fill1_reg  <= '0;
            fill2_reg  <= '0;
            fillc_reg  <= '0;
            damper_reg <= '0;
        end
        else
        begin
            pos1_reg   <= pos1_next;
            pos2_reg   <= pos2_next;
            posc_reg   <= posc_next;
            fill1_reg  <= fill1_next;
            fill2_reg  <= fill2_next;
            fillc_reg  <= fillc_next;
            damper_reg <= damper_next;
        end
    end

    assign sample_out = out_reg;

`ifndef SYNTHESIS
    // First and comb line fill counts never pass the line depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fill1_reg <= (AW+1)'(ALLPASS_DEPTH)) && (fillc_reg <= (CW+1)'(COMB_DEPTH)))
        else $error("fill count beyond line depth");

    // First line writes land inside or just past the written prefix
    a_write_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step == STEP_3) |-> ({1'b0, pos1_reg} <= fill1_reg))
        else $error("first line write outside written prefix");

    // Flush leaves the lines empty and the damper at rest
    a_flush_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step == STEP_FLUSH) |=>
            (damper_reg == '0 && fill1_reg == '0 && fill2_reg == '0 && fillc_reg == '0))
        else $error("flush did not clear state");
`endif

endmodule

/* hdl/acd_ctrl.sv */
module acd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_flush,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output acd_pkg::cmd_t cmd
);
    import acd_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_S1    = 4'd1;
    localparam logic [3:0] ST_S2    = 4'd2;
    localparam logic [3:0] ST_S3    = 4'd3;
    localparam logic [3:0] ST_S4    = 4'd4;
    localparam logic [3:0] ST_S5    = 4'd5;
    localparam logic [3:0] ST_S6    = 4'd6;
    localparam logic [3:0] ST_S7    = 4'd7;
    localparam logic [3:0] ST_S8    = 4'd8;
    localparam logic [3:0] ST_FLUSH = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);

    // Sequencer and command decode
    always_comb
    begin
        state_next   = state_reg;
        cmd.capture  = 1'b0;
        cmd.step     = STEP_NONE;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = in_flush ? ST_FLUSH : ST_S1;
                end
            end
            ST_S1:
            begin
                cmd.step   = STEP_1;
                state_next = ST_S2;
            end
            ST_S2:
            begin
                cmd.step   = STEP_2;
                state_next = ST_S3;
            end
            ST_S3:
            begin
                cmd.step   = STEP_3;
                state_next = ST_S4;
            end
            ST_S4:
            begin
                cmd.step   = STEP_4;
                state_next = ST_S5;
            end
            ST_S5:
            begin
                cmd.step   = STEP_5;
                state_next = ST_S6;
            end
            ST_S6:
            begin
                cmd.step   = STEP_6;
                state_next = ST_S7;
            end
            ST_S7:
            begin
                cmd.step   = STEP_7;
                state_next = ST_S8;
            end
            ST_S8:
            begin
                cmd.step   = STEP_8;
                state_next = ST_DONE;
            end
            ST_FLUSH:
            begin
                cmd.step   = STEP_FLUSH;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid
    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    // A result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> slot_free)
        else $error("result register overwritten");

    // An accepted transaction starts either the compute chain or a flush
    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_S1 || state_reg == ST_FLUSH))
        else $error("accepted transaction not started");

    // Loading the result register raises valid
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");

    // The last compute step always hands over to result delivery
    a_chain_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_S8) |=> (state_reg == ST_DONE))
        else $error("compute chain did not finish");
`endif

endmodule

/* hdl/allpass_comb_diffuser.sv */
// Allpass pair into a damped feedback comb. Each sample transaction runs
// through a chain of six dependent gain products on one shared multiplier,
// so a sample is through the chain and its result loaded before the next
// is accepted; a flush transaction skips the chain. The result sits in an
// output register, and the next sample is taken while it waits. Delay
// lines are plain single-port memories; reset and flush empty them at
// once through per-line fill counts, so there is no clearing pass.
// Configuration writes are to be made only while the block is idle.
module allpass_comb_diffuser #(
    parameter int ALLPASS_DEPTH = 2048,
    parameter int COMB_DEPTH    = 4096,
    parameter int SAMPLE_BITS   = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    acd_sample_if.sink                         sample_ch,
    acd_result_if.source                       result_ch,
    input  logic                               cfg_we,
    input  logic [acd_pkg::REG_INDEX_BITS-1:0] cfg_index,
    input  logic [acd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import acd_pkg::*;

    cmd_t cmd;
    cfg_t cfg;

    // Register bank
    acd_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    // Sequencer
    acd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_ch.valid),
        .in_flush  (sample_ch.flush),
        .in_ready  (sample_ch.ready),
        .out_valid (result_ch.valid),
        .out_ready (result_ch.ready),
        .cmd       (cmd)
    );

    // Arithmetic and delay lines
    acd_datapath #(
        .ALLPASS_DEPTH (ALLPASS_DEPTH),
        .COMB_DEPTH    (COMB_DEPTH),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg        (cfg),
        .sample_in  (sample_ch.sample_in),
        .loop_gain  (sample_ch.loop_gain),
        .sample_out (result_ch.sample_out)
    );

endmodule
